/* rtl/core/range_distinct_count_assert.svh */
// Assertion macros shared by the range distinct count RTL.
`ifndef RANGE_DISTINCT_COUNT_ASSERT_SVH
`define RANGE_DISTINCT_COUNT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define RDC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range_distinct_count: implication check failed");

// Check that a condition never holds.
`define RDC_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("range_distinct_count: forbidden condition seen");

`endif

/* rtl/core/rdc_pkg.sv */
// Package of fixed field widths and opcodes for the range distinct count block.
package rdc_pkg;

    localparam int POS_BITS    = 10;
    localparam int VAL_IN_BITS = 12;
    localparam int CNT_BITS    = 11;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

/* rtl/core/range_distinct_count.sv */
// Range distinct count: value array with point writes and distinct-count range queries.
//
// Request channel (req_valid / req_stall): opcode 0 writes item_value at position,
// opcode 1 asks how many distinct values lie at positions position..range_high.
// Response channel (rsp_valid / rsp_stall): one response per query, none per write.
// Requests are served strictly in arrival order, one at a time.
//
// A write is stored in the cycle it is taken. A query walks the range twice, as
// the value memory has one read port: once to mark values (one position a cycle,
// value read then mark read-modify-write), and once more to clear the marks. An
// inverted range (low end above high end) answers with a zero count and range_error
// set; positions at or beyond ARRAY_DEPTH are skipped.
//
// After reset the block sweeps both memories to zero, one entry a cycle, over
// max(ARRAY_DEPTH, 2**VALUE_BITS) addresses (4096 with the defaults); req_stall is
// high during the sweep. A finished response waits in an output register while
// the receiver stalls; the next request is still taken and worked on, and only its
// own response waits for the register to drain.
module range_distinct_count
    import rdc_pkg::*;
#(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_BITS  = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic                   opcode,
    input  logic [POS_BITS-1:0]    position,
    input  logic [POS_BITS-1:0]    range_high,
    input  logic [VAL_IN_BITS-1:0] item_value,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [CNT_BITS-1:0]    distinct_count,
    output logic                   range_error
);

    localparam int AW         = $clog2(ARRAY_DEPTH);
    localparam int SEEN_DEPTH = 1 << VALUE_BITS;
    localparam int CLR_DEPTH  = (ARRAY_DEPTH > SEEN_DEPTH) ? ARRAY_DEPTH : SEEN_DEPTH;
    localparam int CW         = $clog2(CLR_DEPTH);

    localparam logic [16:0]   DEPTH_CMP   = 17'(ARRAY_DEPTH);
    localparam logic [CW:0]   CLR_V_LIM   = (CW+1)'(ARRAY_DEPTH);
    localparam logic [CW:0]   CLR_S_LIM   = (CW+1)'(SEEN_DEPTH);
    localparam logic [CW-1:0] CLR_LAST    = CW'(CLR_DEPTH - 1);
    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(ARRAY_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_MARK_DRAIN,
        ST_UNMARK,
        ST_UNMARK_DRAIN,
        ST_FINISH
    } state_t;

    // Memories
    logic [VALUE_BITS-1:0] value_mem [ARRAY_DEPTH];
    logic                  seen_mem  [SEEN_DEPTH];

    // Control
    state_t                state_reg;
    logic [CW-1:0]         clr_reg;
    logic [POS_BITS-1:0]   p_reg;
    logic [POS_BITS-1:0]   lo_reg;
    logic [POS_BITS-1:0]   hi_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  err_reg;
    logic                  rsp_valid_reg;
    logic [CNT_BITS-1:0]   rsp_count_reg;
    logic                  rsp_error_reg;

    // Walk pipeline
    logic                  v1_valid_reg;
    logic                  v1_mark_reg;
    logic [VALUE_BITS-1:0] vq_reg;
    logic                  v2_valid_reg;
    logic [VALUE_BITS-1:0] v2_val_reg;
    logic                  sq_reg;
    logic                  v3_valid_reg;
    logic [VALUE_BITS-1:0] v3_val_reg;

    logic                  req_take;
    logic                  pos_in_range;
    logic                  high_in_range;
    logic                  walk_issue;
    logic                  mark_hit;
    logic                  mark_new;
    logic                  rsp_free;

    logic                  vmem_we;
    logic [AW-1:0]         vmem_waddr;
    logic [VALUE_BITS-1:0] vmem_wdata;
    logic                  smem_we;
    logic [VALUE_BITS-1:0] smem_waddr;
    logic                  smem_wdata;

    assign req_stall      = (state_reg != ST_IDLE);
    assign req_take       = req_valid && !req_stall;
    assign pos_in_range   = ({7'b0, position} < DEPTH_CMP);
    assign high_in_range  = ({7'b0, range_high} < DEPTH_CMP);
    assign walk_issue     = (state_reg == ST_MARK) || (state_reg == ST_UNMARK);
    assign rsp_free       = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid      = rsp_valid_reg;
    assign distinct_count = rsp_count_reg;
    assign range_error    = rsp_error_reg;

    // Forward the mark set by the position just ahead in the walk: its read raced that write.
    assign mark_hit = sq_reg || (v3_valid_reg && (v3_val_reg == v2_val_reg));
    assign mark_new = v2_valid_reg && !mark_hit;

    // Value memory write port: reset sweep or write request
    always_comb
    begin
        vmem_we    = 1'b0;
        vmem_waddr = AW'(position);
        vmem_wdata = VALUE_BITS'(item_value);
        if (state_reg == ST_CLEAR)
        begin
            vmem_we    = ({1'b0, clr_reg} < CLR_V_LIM);
            vmem_waddr = AW'(clr_reg);
            vmem_wdata = '0;
        end
        else if (req_take && (opcode == OP_WRITE) && pos_in_range)
        begin
            vmem_we = 1'b1;
        end
    end

    // Mark memory write port: reset sweep, new mark, or clearing walk
    always_comb
    begin
        smem_we    = 1'b0;
        smem_waddr = v2_val_reg;
        smem_wdata = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            smem_we    = ({1'b0, clr_reg} < CLR_S_LIM);
            smem_waddr = VALUE_BITS'(clr_reg);
            smem_wdata = 1'b0;
        end
        else if (mark_new)
        begin
            smem_we = 1'b1;
        end
        else if (v1_valid_reg && !v1_mark_reg)
        begin
            smem_we    = 1'b1;
            smem_waddr = vq_reg;
            smem_wdata = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            value_mem[vmem_waddr] <= vmem_wdata;
        end
        if (walk_issue)
        begin
            vq_reg <= value_mem[AW'(p_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            seen_mem[smem_waddr] <= smem_wdata;
        end
        if (v1_valid_reg && v1_mark_reg)
        begin
            sq_reg <= seen_mem[vq_reg];
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        v2_val_reg <= vq_reg;
        v3_val_reg <= v2_val_reg;
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_valid_reg <= 1'b0;
            v1_mark_reg  <= 1'b0;
            v2_valid_reg <= 1'b0;
            v3_valid_reg <= 1'b0;
        end
        else
        begin
            v1_valid_reg <= walk_issue;
            v1_mark_reg  <= (state_reg == ST_MARK);
            v2_valid_reg <= v1_valid_reg && v1_mark_reg;
            v3_valid_reg <= v2_valid_reg;
        end
    end

    // Sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            p_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_count_reg <= '0;
            rsp_error_reg <= 1'b0;
        end
        else
        begin
            // drop the response once taken; a finishing query reloads it below
            if (rsp_valid_reg && !rsp_stall && (state_reg != ST_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (mark_new)
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_take && (opcode == OP_QUERY))
                    begin
                        cnt_reg <= '0;
                        p_reg   <= position;
                        lo_reg  <= position;
                        err_reg <= (position > range_high);
                        if (position > range_high)
                        begin
                            hi_reg    <= position;
                            state_reg <= ST_FINISH;
                        end
                        else if (!pos_in_range)
                        begin
                            hi_reg    <= position;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            hi_reg    <= high_in_range ? range_high : POS_LAST;
                            state_reg <= ST_MARK;
                        end
                    end
                end
                ST_MARK:
                begin
                    p_reg <= p_reg + POS_BITS'(1);
                    if (p_reg == hi_reg)
                    begin
                        state_reg <= ST_MARK_DRAIN;
                    end
                end
                ST_MARK_DRAIN:
                begin
                    if (!v1_valid_reg && !v2_valid_reg)
                    begin
                        p_reg     <= lo_reg;
                        state_reg <= ST_UNMARK;
                    end
                end
                ST_UNMARK:
                begin
                    p_reg <= p_reg + POS_BITS'(1);
                    if (p_reg == hi_reg)
                    begin
                        state_reg <= ST_UNMARK_DRAIN;
                    end
                end
                ST_UNMARK_DRAIN:
                begin
                    if (!v1_valid_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold the result until the response register is free
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_count_reg <= cnt_reg;
                        rsp_error_reg <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks

`include "range_distinct_count_assert.svh"

    `RDC_ASSERT_NEVER(a_seen_port_clash, mark_new && v1_valid_reg && !v1_mark_reg)
    `RDC_ASSERT_IMPL(a_sweep_quiet, state_reg == ST_CLEAR,
        !v1_valid_reg && !v2_valid_reg && !v3_valid_reg)
    `RDC_ASSERT_IMPL(a_count_bound, (state_reg == ST_FINISH) && !err_reg,
        cnt_reg <= ({1'b0, hi_reg} - {1'b0, lo_reg} + CNT_BITS'(1)))
    `RDC_ASSERT_IMPL(a_error_zero, (state_reg == ST_FINISH) && err_reg,
        cnt_reg == '0)

endmodule
